// ----- rtl/core/bla_pkg.sv -----
// shared types and constants of the battery level averaging lookup block
package bla_pkg;

   // field widths
   localparam int SAMPLE_W   = 12;
   localparam int MV_W       = 16;
   localparam int FACTOR_W   = 16;
   localparam int RATIO_W    = 4;
   localparam int ENTRY_W    = 6;
   localparam int LEVEL_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // item function codes
   localparam logic FUNC_SAMPLE      = 1'b0;
   localparam logic FUNC_TABLE_WRITE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MV_FACTOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_RATIO = 1'b1;

   // register reset values
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd52973;
   localparam logic [RATIO_W-1:0]  RATIO_RESET  = 4'd2;

   // input beat
   typedef struct packed {
      logic                func;
      logic [SAMPLE_W-1:0] sample;
      logic                report_voltage;
      logic [ENTRY_W-1:0]  entry_index;
      logic [MV_W-1:0]     entry_millivolts;
   } req_type;

   // result beat
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [ENTRY_W-1:0] nearest_entry;
   } rsp_type;

   // control of one table cell
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   // status of the divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- rtl/core/bla_win_cell.sv -----
// one sample cell of the averaging window chain
module bla_win_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift,
   input  logic [bla_pkg::SAMPLE_W-1:0]  data_in,
   output logic [bla_pkg::SAMPLE_W-1:0]  data_out
);

   logic [bla_pkg::SAMPLE_W-1:0] value_ff;
   logic [bla_pkg::SAMPLE_W-1:0] value_in;

   // take the neighbor's sample on a shift
   always_comb begin
      value_in = shift ? data_in : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign data_out = value_ff;

endmodule

// ----- rtl/core/bla_tab_cell.sv -----
// one entry cell of the voltage table ring
module bla_tab_cell (
   input  logic                       clock,
   input  bla_pkg::cell_ctl_type      ctl,
   input  logic [bla_pkg::MV_W-1:0]   load_data,
   input  logic [bla_pkg::MV_W-1:0]   data_in,
   output logic [bla_pkg::MV_W-1:0]   data_out
);

   logic [bla_pkg::MV_W-1:0] value_ff;
   logic [bla_pkg::MV_W-1:0] value_in;

   // table write, or rotate toward cell zero during the search
   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = load_data;
      end else if (ctl.shift) begin
         value_in = data_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign data_out = value_ff;

endmodule

// ----- rtl/core/bla_div.sv -----
// divide by a fixed divisor through a reciprocal multiply of the registered dividend
module bla_div #(
   parameter int DIVIDEND_W = 18,
   parameter int DIVISOR    = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_W-1:0]    dividend,
   output logic [DIVIDEND_W-1:0]    quotient,
   output bla_pkg::div_stat_type    stat
);

   // shift and rounded-up reciprocal, exact for every dividend of DIVIDEND_W bits
   localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
   localparam int RECIP_W = DIVIDEND_W + 1;
   localparam int PROD_W  = SHIFT + DIVIDEND_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT + DIVISOR - 1) / DIVISOR);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   // capture the dividend, then multiply by the reciprocal
   always_comb begin
      busy_in = 1'b0;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         done_in = 1'b1;
         prod_in = PROD_W'(dvd_ff) * PROD_W'(RECIP);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      prod_ff <= prod_in;
   end

   assign quotient  = prod_ff[SHIFT +: DIVIDEND_W];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/core/battery_level_averaging_lookup_top.sv -----
// top level: moving average of converter samples and nearest voltage table match
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   bla_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall   bla_pkg::rsp_type
//   csr      in         csr_write               csr_index, csr_wdata
//
// a table-write beat leaves req_stall low; after a sample beat req_stall stays
// high while the sequencer steps through the reciprocal divide, the scaling,
// the search as the table ring rotates past the comparator, and the result.
// the result sits in an output register, so a stalled rsp does not hold off
// the next beat unless a new result is ready. reset clears the window and the
// registers; the table holds nothing defined until written.
module battery_level_averaging_lookup_top #(
   parameter int WINDOW_LENGTH = 20,
   parameter int TABLE_ENTRIES = 50
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bla_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bla_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write,
   input  logic [bla_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bla_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SUM_W   = bla_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int TAB_W   = $clog2(TABLE_ENTRIES);
   localparam int SUM_MAX = WINDOW_LENGTH * ((1 << bla_pkg::SAMPLE_W) - 1);
   localparam int PROD_W  = bla_pkg::SAMPLE_W + bla_pkg::FACTOR_W;
   localparam logic [TAB_W-1:0] LAST_ENTRY = TAB_W'(TABLE_ENTRIES - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIV    = 5'b00010,
      ST_SCALE  = 5'b00100,
      ST_SEARCH = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [bla_pkg::FACTOR_W-1:0] factor_ff, factor_in;
   logic [bla_pkg::RATIO_W-1:0]  ratio_ff, ratio_in;

   logic                         req_take;
   logic                         take_sample;
   logic                         take_write;
   logic                         report_ff, report_in;

   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [bla_pkg::SAMPLE_W-1:0] win_q [WINDOW_LENGTH];

   logic [SUM_W-1:0]             quotient;
   bla_pkg::div_stat_type        div_stat;
   logic [PROD_W-1:0]            scaled;
   logic [bla_pkg::SAMPLE_W-1:0] pin_ff, pin_in;
   logic [bla_pkg::MV_W-1:0]     mv_ff, mv_in;

   logic [bla_pkg::MV_W-1:0]     tab_q [TABLE_ENTRIES];
   logic                         ring_shift;
   logic [TAB_W-1:0]             cnt_ff, cnt_in;
   logic [bla_pkg::MV_W-1:0]     diff;
   logic                         better;
   logic [bla_pkg::MV_W-1:0]     best_diff_ff, best_diff_in;
   logic [TAB_W-1:0]             best_idx_ff, best_idx_in;
   logic [bla_pkg::ENTRY_W-1:0]  best_entry;

   logic                         out_free;
   logic                         rsp_load;
   logic                         rsp_valid_ff, rsp_valid_in;
   bla_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   // configuration writes
   always_comb begin
      factor_in = factor_ff;
      ratio_in  = ratio_ff;
      if (csr_write) begin
         case (csr_index)
            bla_pkg::CSR_MV_FACTOR: factor_in = csr_wdata;
            bla_pkg::CSR_DIV_RATIO: ratio_in  = csr_wdata[bla_pkg::RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   // input handshake
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign take_sample = req_take && (req_data.func == bla_pkg::FUNC_SAMPLE);
   assign take_write  = req_take && (req_data.func == bla_pkg::FUNC_TABLE_WRITE);
   assign report_in   = take_sample ? req_data.report_voltage : report_ff;

   // running window sum: add the new sample, drop the one leaving cell zero
   assign sum_in = take_sample
      ? sum_ff + SUM_W'(req_data.sample) - SUM_W'(win_q[0])
      : sum_ff;

   // window chain, oldest sample in cell zero
   for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_win
      if (i == WINDOW_LENGTH - 1) begin : g_tail
         bla_win_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (take_sample),
            .data_in  (req_data.sample),
            .data_out (win_q[i])
         );
      end else begin : g_body
         bla_win_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (take_sample),
            .data_in  (win_q[i+1]),
            .data_out (win_q[i])
         );
      end
   end

   // average = sum / WINDOW_LENGTH, truncated
   bla_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR    (WINDOW_LENGTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (take_sample),
      .dividend (sum_in),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // pin millivolts, then battery millivolts; 4095 * 15 fits 16 bits, no clip needed
   assign scaled = PROD_W'(quotient[bla_pkg::SAMPLE_W-1:0]) * PROD_W'(factor_ff);
   assign pin_in = (state_ff == ST_DIV && div_stat.done)
      ? scaled[PROD_W-1:bla_pkg::FACTOR_W] : pin_ff;
   assign mv_in  = (state_ff == ST_SCALE)
      ? bla_pkg::MV_W'(pin_ff) * bla_pkg::MV_W'(ratio_ff) : mv_ff;

   // table ring, rotating toward cell zero during the search
   assign ring_shift = (state_ff == ST_SEARCH);

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_tab
      bla_pkg::cell_ctl_type ctl;
      assign ctl.load  = take_write && (req_data.entry_index == bla_pkg::ENTRY_W'(i));
      assign ctl.shift = ring_shift;
      bla_tab_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_data (req_data.entry_millivolts),
         .data_in   (tab_q[(i + 1) % TABLE_ENTRIES]),
         .data_out  (tab_q[i])
      );
   end

   // nearest match at cell zero; the first entry always wins, then strictly closer
   always_comb begin
      diff   = (mv_ff >= tab_q[0]) ? (mv_ff - tab_q[0]) : (tab_q[0] - mv_ff);
      better = (cnt_ff == '0) || (diff < best_diff_ff);
      best_diff_in = best_diff_ff;
      best_idx_in  = best_idx_ff;
      cnt_in       = cnt_ff;
      if (state_ff == ST_SCALE) begin
         cnt_in = '0;
      end else if (ring_shift) begin
         cnt_in = cnt_ff + 1'b1;
         if (better) begin
            best_diff_in = diff;
            best_idx_in  = cnt_ff;
         end
      end
   end

   // result beat into the output register
   assign best_entry = bla_pkg::ENTRY_W'(best_idx_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == ST_RESULT) && out_free;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.nearest_entry = best_entry;
         rsp_data_in.level = report_ff ? mv_ff
            : {{(bla_pkg::LEVEL_W - bla_pkg::ENTRY_W - 1){1'b0}}, best_entry, 1'b0};
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (take_sample) state_in = ST_DIV;
         ST_DIV:    if (div_stat.done) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_SEARCH;
         ST_SEARCH: if (cnt_ff == LAST_ENTRY) state_in = ST_RESULT;
         ST_RESULT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         factor_ff    <= bla_pkg::FACTOR_RESET;
         ratio_ff     <= bla_pkg::RATIO_RESET;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         ratio_ff     <= ratio_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      report_ff    <= report_in;
      pin_ff       <= pin_in;
      mv_ff        <= mv_in;
      cnt_ff       <= cnt_in;
      best_diff_ff <= best_diff_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result only follows the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_RESULT))
      else $error("result beat without a finished search");

   // the divider is working or finishing whenever the sequencer waits on it
   a_div_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_stat.busy || div_stat.done))
      else $error("sequencer waits on an idle divider");

   // the search starts from entry zero right after scaling
   a_search_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) && $past(state_ff == ST_SCALE) |-> (cnt_ff == '0))
      else $error("search did not start at entry zero");

   // running sum stays within a full window of maximum samples
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_W'(SUM_MAX))
      else $error("window sum out of range");

endmodule

// ----- tb/tb_top.sv -----
// testbench for the battery level averaging lookup block
`timescale 1ns / 1ps

module tb_top;

   localparam int WINDOW_LENGTH  = 20;
   localparam int TABLE_ENTRIES  = 50;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRINT_LIMIT    = 200;

   // clock and dut ports
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   bla_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   bla_pkg::rsp_type               rsp_data;
   logic                           csr_write = 1'b0;
   logic [bla_pkg::CSR_IDX_W-1:0]  csr_index = bla_pkg::CSR_MV_FACTOR;
   logic [bla_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted block state
   logic [bla_pkg::SAMPLE_W-1:0] sample_window [WINDOW_LENGTH] = '{default: '0};
   logic [bla_pkg::MV_W-1:0]     volt_table [TABLE_ENTRIES];
   logic [bla_pkg::FACTOR_W-1:0] factor_q = bla_pkg::FACTOR_RESET;
   logic [bla_pkg::RATIO_W-1:0]  ratio_q = bla_pkg::RATIO_RESET;
   bla_pkg::rsp_type             expected_levels [$];

   // traffic shaping
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_request = 0;
   int          hold_left = 0;
   int          drift_level = 2048;
   int unsigned top_mv = 6820;

   // bookkeeping
   int mismatch_count = 0;
   int results_seen = 0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   battery_level_averaging_lookup_top #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // battery millivolts once newest is shifted into the window
   function automatic logic [bla_pkg::MV_W-1:0] window_millivolts(
      input logic [bla_pkg::SAMPLE_W-1:0] newest);
      int unsigned total;
      int unsigned average;
      int unsigned pin_mv;
      int unsigned battery_mv;
      total = newest;
      for (int i = 1; i < WINDOW_LENGTH; i++) total += sample_window[i];
      average = total / WINDOW_LENGTH;
      pin_mv = (average * factor_q) >> 16;
      battery_mv = pin_mv * ratio_q;
      if (battery_mv > 32'hFFFF) battery_mv = 32'hFFFF;
      return battery_mv[bla_pkg::MV_W-1:0];
   endfunction

   // table entry closest to mv, lowest index on a tie
   function automatic logic [bla_pkg::ENTRY_W-1:0] closest_entry(
      input logic [bla_pkg::MV_W-1:0] mv);
      int unsigned best_gap;
      int unsigned gap;
      int unsigned probe;
      int unsigned stored;
      logic [bla_pkg::ENTRY_W-1:0] best;
      best = '0;
      best_gap = 32'h10000;
      probe = mv;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         stored = volt_table[i];
         gap = (probe >= stored) ? probe - stored : stored - probe;
         if (gap < best_gap) begin
            best_gap = gap;
            best = bla_pkg::ENTRY_W'(i);
         end
      end
      return best;
   endfunction

   // fold one accepted beat into the predicted state
   task automatic track_beat(input bla_pkg::req_type beat);
      bla_pkg::rsp_type want;
      logic [bla_pkg::MV_W-1:0] mv;
      if (beat.func == bla_pkg::FUNC_TABLE_WRITE) begin
         if (beat.entry_index < TABLE_ENTRIES)
            volt_table[beat.entry_index] = beat.entry_millivolts;
      end else begin
         mv = window_millivolts(beat.sample);
         for (int i = 0; i < WINDOW_LENGTH - 1; i++) sample_window[i] = sample_window[i+1];
         sample_window[WINDOW_LENGTH-1] = beat.sample;
         want.nearest_entry = closest_entry(mv);
         want.level = beat.report_voltage ? mv
            : bla_pkg::LEVEL_W'(want.nearest_entry) << 1;
         expected_levels.push_back(want);
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("mismatch at result %0d: %s", results_seen, what);
   endtask

   // compare one result beat with the oldest prediction
   task automatic check_result(input bla_pkg::rsp_type got);
      bla_pkg::rsp_type want;
      results_seen++;
      if (expected_levels.size() == 0) begin
         report_mismatch($sformatf("unexpected result level %0d entry %0d",
                                   got.level, got.nearest_entry));
         return;
      end
      want = expected_levels.pop_front();
      if (got.level !== want.level)
         report_mismatch($sformatf("level %0d, predicted %0d", got.level, want.level));
      if (got.nearest_entry !== want.nearest_entry)
         report_mismatch($sformatf("nearest_entry %0d, predicted %0d",
                                   got.nearest_entry, want.nearest_entry));
   endtask

   // result side: check accepted beats, then drive stall for the next edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("battery_level_averaging_lookup_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one beat, leaving valid high after it is taken
   task automatic send_beat(input bla_pkg::req_type beat);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      track_beat(beat);
   endtask

   // beat with every field random
   function automatic bla_pkg::req_type noise_beat();
      bla_pkg::req_type beat;
      beat.func = 1'($urandom_range(1));
      beat.sample = bla_pkg::SAMPLE_W'($urandom_range(4095));
      beat.report_voltage = 1'($urandom_range(1));
      beat.entry_index = bla_pkg::ENTRY_W'($urandom_range(63));
      beat.entry_millivolts = bla_pkg::MV_W'($urandom_range(65535));
      return beat;
   endfunction

   task automatic write_entry(input logic [bla_pkg::ENTRY_W-1:0] index,
                              input logic [bla_pkg::MV_W-1:0] mv);
      bla_pkg::req_type beat;
      beat = noise_beat();
      beat.func = bla_pkg::FUNC_TABLE_WRITE;
      beat.entry_index = index;
      beat.entry_millivolts = mv;
      send_beat(beat);
   endtask

   task automatic send_sample(input logic [bla_pkg::SAMPLE_W-1:0] reading,
                              input logic report_mv);
      bla_pkg::req_type beat;
      beat = noise_beat();
      beat.func = bla_pkg::FUNC_SAMPLE;
      beat.sample = reading;
      beat.report_voltage = report_mv;
      send_beat(beat);
   endtask

   // converter reading that drifts around a wandering level
   function automatic logic [bla_pkg::SAMPLE_W-1:0] next_sample();
      int reading;
      if ($urandom_range(15) == 0) drift_level = int'($urandom_range(4095));
      if ($urandom_range(9) == 0) return bla_pkg::SAMPLE_W'($urandom_range(4095));
      reading = drift_level + int'($urandom_range(128)) - 64;
      if (reading < 0) reading = 0;
      if (reading > 4095) reading = 4095;
      return bla_pkg::SAMPLE_W'(reading);
   endfunction

   // mostly samples, some table rewrites, a few writes at any index, some past the table
   function automatic bla_pkg::req_type random_beat();
      bla_pkg::req_type beat;
      int unsigned pick;
      beat = noise_beat();
      pick = $urandom_range(99);
      if (pick < 80) begin
         beat.func = bla_pkg::FUNC_SAMPLE;
         beat.sample = next_sample();
      end else begin
         beat.func = bla_pkg::FUNC_TABLE_WRITE;
         if (pick < 96) beat.entry_index = bla_pkg::ENTRY_W'($urandom_range(TABLE_ENTRIES - 1));
         if ($urandom_range(3) != 0) beat.entry_millivolts = bla_pkg::MV_W'($urandom_range(top_mv));
      end
      return beat;
   endfunction

   // stop offering beats and let the block go quiet
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [bla_pkg::FACTOR_W-1:0] factor,
                             input logic [bla_pkg::RATIO_W-1:0] ratio);
      int unsigned ceiling;
      drain_results();
      csr_write <= 1'b1;
      csr_index <= bla_pkg::CSR_MV_FACTOR;
      csr_wdata <= factor;
      @(posedge clock);
      csr_index <= bla_pkg::CSR_DIV_RATIO;
      csr_wdata <= bla_pkg::CSR_DATA_W'(ratio);
      @(posedge clock);
      csr_write <= 1'b0;
      factor_q = factor;
      ratio_q = ratio;
      // table values for random writes stay near reachable voltages
      ceiling = ((32'd4095 * factor) >> 16) * ratio + 200;
      top_mv = (ceiling > 65535) ? 65535 : ceiling;
   endtask

   // every entry written once, evenly spread, before any sample
   task automatic load_voltage_table();
      for (int i = 0; i < TABLE_ENTRIES; i++)
         write_entry(bla_pkg::ENTRY_W'(i), bla_pkg::MV_W'(i * 140));
   endtask

   // registers left at their reset values
   task automatic test_reset_registers();
      send_sample(12'd0, 1'b0);
      send_sample(12'hFFF, 1'b1);
      send_sample(12'hFFF, 1'b0);
      send_sample(12'd2048, 1'b1);
   endtask

   // equal distances resolve to the lower index
   task automatic test_nearest_ties();
      int centre;
      // one entry above and one below by the same gap
      centre = window_millivolts(12'd3000);
      write_entry(bla_pkg::ENTRY_W'(10), bla_pkg::MV_W'(centre + 7));
      write_entry(bla_pkg::ENTRY_W'(20), bla_pkg::MV_W'(centre - 7));
      send_sample(12'd3000, 1'b1);
      // two identical entries on the exact voltage
      centre = window_millivolts(12'd3000);
      write_entry(bla_pkg::ENTRY_W'(31), bla_pkg::MV_W'(centre));
      write_entry(bla_pkg::ENTRY_W'(30), bla_pkg::MV_W'(centre));
      send_sample(12'd3000, 1'b0);
   endtask

   // writes past the table end must not land anywhere
   task automatic test_ignored_entry_index();
      int centre;
      centre = window_millivolts(12'd100);
      write_entry(bla_pkg::ENTRY_W'(TABLE_ENTRIES), bla_pkg::MV_W'(centre));
      write_entry('1, bla_pkg::MV_W'(centre));
      send_sample(12'd100, 1'b0);
   endtask

   // zero factor, full scale, and a zero divider ratio
   task automatic test_register_extremes();
      set_config('0, 4'd1);
      send_sample(12'hFFF, 1'b1);
      send_sample(12'hFFF, 1'b0);
      set_config('1, 4'hF);
      for (int i = 0; i < WINDOW_LENGTH; i++) send_sample(12'hFFF, i[0]);
      set_config(bla_pkg::FACTOR_RESET, 4'd0);
      send_sample(12'hFFF, 1'b1);
      send_sample(12'd0, 1'b0);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                      input logic [bla_pkg::FACTOR_W-1:0] factor,
                                      input logic [bla_pkg::RATIO_W-1:0] ratio);
      set_config(factor, ratio);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) send_beat(random_beat());
   endtask

   // long receiver hold-off while samples keep coming
   task automatic test_output_backpressure();
      bla_pkg::req_type beat;
      drain_results();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 600;
      for (int i = 0; i < 16; i++) begin
         beat = random_beat();
         beat.func = bla_pkg::FUNC_SAMPLE;
         send_beat(beat);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_voltage_table();
      test_reset_registers();
      test_nearest_ties();
      test_ignored_entry_index();
      test_register_extremes();
      test_random_traffic(100, 31, 73, bla_pkg::FACTOR_RESET, bla_pkg::RATIO_RESET);
      test_random_traffic(100, 73, 31, bla_pkg::FACTOR_W'($urandom_range(65535)),
                          bla_pkg::RATIO_W'($urandom_range(1, 15)));
      test_random_traffic(100, 0, 0, bla_pkg::FACTOR_W'($urandom_range(65535)),
                          bla_pkg::RATIO_W'($urandom_range(15)));
      test_output_backpressure();
      drain_results();
      if (mismatch_count == 0)
         $display("battery_level_averaging_lookup_top regression: pass");
      else
         $display("battery_level_averaging_lookup_top regression: fail");
      $finish;
   end

endmodule
